@@ hw/rtl/fvn_pkg.sv @@
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types, constants and hash helpers for the fractal value noise unit.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int HASH_BITS_DEF   = 24;

    localparam int VAL_W     = 24;
    localparam int COORD_W   = 32;
    localparam int WEIGHT_W  = 16;
    localparam int NOISE_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int CELL_LAT  = 8;

    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;
    localparam logic [31:0] AXIS_KEY [3] = '{32'h1f123bb5, 32'h9e3779b9, 32'h94d049bb};

    localparam int STEP_2D = 31;
    localparam int STEP_3D = 57;

    localparam logic [3:0] OCT_RESET = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED    = 2'd0,
        CFG_OCTAVES = 2'd1,
        CFG_TWO_DIM = 2'd2,
        CFG_RIDGED  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] seed;
        logic [3:0]  octaves;
        logic        two_dim;
        logic        ridged;
    } t_cfg;

    function automatic logic [31:0] f_xs16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] f_xs15(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

    function automatic logic [VAL_W-1:0] f_blend(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [WEIGHT_W-1:0] w);
        logic [VAL_W+WEIGHT_W:0] m;
        m = a * (17'h10000 - {1'b0, w}) + b * w;
        return m[VAL_W+WEIGHT_W-1:WEIGHT_W];
    endfunction

endpackage

@@ hw/rtl/fvn_point_if.sv @@
// ----------------------------------------------------------------------------
// fvn_point_if
// Point channel: valid, ready and signed Q16.16 x, y, z coordinates.
// ----------------------------------------------------------------------------
interface fvn_point_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_coord;
    logic [31:0] y_coord;
    logic [31:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface

@@ hw/rtl/fvn_noise_if.sv @@
// ----------------------------------------------------------------------------
// fvn_noise_if
// Noise channel: valid, ready and unsigned Q1.16 noise value.
// ----------------------------------------------------------------------------
interface fvn_noise_if;
    logic        valid;
    logic        ready;
    logic [16:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

@@ hw/rtl/fvn_cell.sv @@
// ----------------------------------------------------------------------------
// fvn_cell
// One octave: lattice hash of eight corners, smoothstep blend, accumulate.
// Passes coordinates and running sum to the next cell through a matching delay line.
// ----------------------------------------------------------------------------
module fvn_cell #(
    parameter int OCT         = 0,
    parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF,
    parameter int HASH_BITS   = fvn_pkg::HASH_BITS_DEF,
    localparam int SUM_W      = fvn_pkg::VAL_W + MAX_OCTAVES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  fvn_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic [31:0]          i_x,
    input  logic [31:0]          i_y,
    input  logic [31:0]          i_z,
    input  logic [SUM_W-1:0]     i_sum,
    output logic                 o_valid,
    output logic [31:0]          o_x,
    output logic [31:0]          o_y,
    output logic [31:0]          o_z,
    output logic [SUM_W-1:0]     o_sum
);

    localparam int LAT = fvn_pkg::CELL_LAT;
    localparam int VW  = fvn_pkg::VAL_W;

    logic [63:0]            u   [3];
    logic [FRAC_BITS+15:0]  ft  [3];
    logic [15:0]            t   [3];
    logic [31:0]            lv  [6];
    logic [31:0]            n1_p [6];
    logic [31:0]            n1_tt [3];
    logic [17:0]            n1_g [3];
    logic [31:0]            n1_seed;
    logic [49:0]            pw  [3];
    logic [31:0]            n2_q [6];
    logic [15:0]            n2_w [3];
    logic [31:0]            n3_r [6];
    logic [31:0]            ax  [6];
    logic [31:0]            hc  [8];
    logic [31:0]            n4_h [8];
    logic [31:0]            n5_h [8];
    logic [31:0]            hv  [8];
    logic [VW-1:0]          cv  [8];
    logic [VW-1:0]          n6_a [4];
    logic [VW-1:0]          n7_b [2];
    logic [VW-1:0]          oval;
    logic [SUM_W-1:0]       n8_sum;
    logic                   active;

    logic [31:0]     r1_p [6];
    logic [31:0]     r1_tt [3];
    logic [17:0]     r1_g [3];
    logic [31:0]     r1_seed, r2_seed, r3_seed;
    logic [31:0]     r2_q [6];
    logic [31:0]     r3_r [6];
    logic [31:0]     r4_h [8];
    logic [31:0]     r5_h [8];
    logic [VW-1:0]   r6_a [4];
    logic [VW-1:0]   r7_b [2];
    logic [15:0]     r2_w [3];
    logic [15:0]     r3_w [3];
    logic [15:0]     r4_w [3];
    logic [15:0]     r5_w [3];
    logic [15:0]     r6_w [3];
    logic [15:0]     r7_w [3];
    logic [SUM_W-1:0] r8_sum;
    logic            r_vd [LAT];
    logic [31:0]     r_xd [LAT];
    logic [31:0]     r_yd [LAT];
    logic [31:0]     r_zd [LAT];
    logic [SUM_W-1:0] r_sd [LAT-1];

    always_comb begin
        u[0] = {{32{i_x[31]}}, i_x} << OCT;
        u[1] = {{32{i_y[31]}}, i_y} << OCT;
        u[2] = {{32{i_z[31]}}, i_z} << OCT;
        for (int k = 0; k < 3; k++) begin
            ft[k] = {u[k][FRAC_BITS-1:0], 16'h0000};
            t[k]  = ft[k][FRAC_BITS+15:FRAC_BITS];
            lv[2*k]   = u[k][FRAC_BITS+31:FRAC_BITS];
            lv[2*k+1] = lv[2*k] + 32'd1;
        end
        if (i_cfg.two_dim) begin
            lv[2] = '0;
            lv[3] = '0;
            t[1]  = '0;
        end
        for (int j = 0; j < 6; j++) begin
            n1_p[j] = lv[j] * fvn_pkg::AXIS_KEY[j/2];
        end
        for (int k = 0; k < 3; k++) begin
            n1_tt[k] = t[k] * t[k];
            n1_g[k]  = 18'd196608 - {1'b0, t[k], 1'b0};
        end
        n1_seed = i_cfg.seed + (i_cfg.two_dim ? 32'(OCT * fvn_pkg::STEP_2D)
                                              : 32'(OCT * fvn_pkg::STEP_3D));
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n2_q[j] = fvn_pkg::f_xs16(r1_p[j]) * fvn_pkg::MIX_C1;
            n3_r[j] = fvn_pkg::f_xs15(r2_q[j]) * fvn_pkg::MIX_C2;
            ax[j]   = fvn_pkg::f_xs16(r3_r[j]);
        end
        for (int k = 0; k < 3; k++) begin
            pw[k]   = r1_tt[k] * r1_g[k];
            n2_w[k] = pw[k][47:32];
        end
        for (int c = 0; c < 8; c++) begin
            hc[c]   = r3_seed ^ ax[c & 1] ^ ax[2 + ((c >> 1) & 1)] ^ ax[4 + ((c >> 2) & 1)];
            n4_h[c] = fvn_pkg::f_xs16(hc[c]) * fvn_pkg::MIX_C1;
            n5_h[c] = fvn_pkg::f_xs15(r4_h[c]) * fvn_pkg::MIX_C2;
            hv[c]   = fvn_pkg::f_xs16(r5_h[c]);
            cv[c]   = VW'(hv[c][HASH_BITS-1:0]) << (VW - HASH_BITS);
        end
        for (int i = 0; i < 4; i++) begin
            n6_a[i] = fvn_pkg::f_blend(cv[2*i], cv[2*i+1], r5_w[0]);
        end
        for (int i = 0; i < 2; i++) begin
            n7_b[i] = fvn_pkg::f_blend(r6_a[2*i], r6_a[2*i+1], r6_w[1]);
        end
        oval   = fvn_pkg::f_blend(r7_b[0], r7_b[1], r7_w[2]);
        active = (5'(OCT) < {1'b0, i_cfg.octaves});
        n8_sum = active ? ((r_sd[LAT-2] << 1) + SUM_W'(oval)) : r_sd[LAT-2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_vd[s] <= 1'b0;
        end else if (i_en) begin
            r_vd[0] <= i_valid;
            for (int s = 1; s < LAT; s++) r_vd[s] <= r_vd[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= n1_p;
            r1_tt   <= n1_tt;
            r1_g    <= n1_g;
            r1_seed <= n1_seed;
            r2_q    <= n2_q;
            r2_w    <= n2_w;
            r2_seed <= r1_seed;
            r3_r    <= n3_r;
            r3_w    <= r2_w;
            r3_seed <= r2_seed;
            r4_h    <= n4_h;
            r4_w    <= r3_w;
            r5_h    <= n5_h;
            r5_w    <= r4_w;
            r6_a    <= n6_a;
            r6_w    <= r5_w;
            r7_b    <= n7_b;
            r7_w    <= r6_w;
            r8_sum  <= n8_sum;
            r_xd[0] <= i_x;
            r_yd[0] <= i_y;
            r_zd[0] <= i_z;
            r_sd[0] <= i_sum;
            for (int s = 1; s < LAT; s++) begin
                r_xd[s] <= r_xd[s-1];
                r_yd[s] <= r_yd[s-1];
                r_zd[s] <= r_zd[s-1];
            end
            for (int s = 1; s < LAT-1; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    assign o_valid = r_vd[LAT-1];
    assign o_x     = r_xd[LAT-1];
    assign o_y     = r_yd[LAT-1];
    assign o_z     = r_zd[LAT-1];
    assign o_sum   = r8_sum;

endmodule

@@ hw/rtl/fvn_norm.sv @@
// ----------------------------------------------------------------------------
// fvn_norm
// Divide the octave sum by 2^n-1 via reciprocal and correction, then apply
// the optional ridge fold and register the result.
// ----------------------------------------------------------------------------
module fvn_norm #(
    parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
    localparam int SUM_W      = fvn_pkg::VAL_W + MAX_OCTAVES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fvn_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  logic [SUM_W-1:0]   i_sum,
    output logic               o_valid,
    output logic [16:0]        o_noise
);

    localparam int VW    = fvn_pkg::VAL_W;
    localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int NW    = $clog2(MAX_OCTAVES + 1);

    logic [SUM_W:0]        recip [MAX_OCTAVES];
    logic [NW-1:0]         n_eff;
    logic [IDX_W-1:0]      idx;
    logic [2*SUM_W:0]      prod;
    logic [SUM_W-1:0]      dv;
    logic [SUM_W-1:0]      qd;
    logic [SUM_W-1:0]      rem;
    logic [VW-1:0]         n_v;
    logic [VW:0]           twice;
    logic [VW:0]           dev;
    logic [VW:0]           fold;
    logic [16:0]           n_noise;

    logic                  r_va, r_vb, r_vo;
    logic [VW-1:0]         r_q0;
    logic [SUM_W-1:0]      r_s1;
    logic [VW-1:0]         r_v;
    logic [16:0]           r_noise;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_recip
        localparam logic [63:0] RV = (64'd1 << SUM_W) / ((64'd1 << (g + 1)) - 64'd1);
        assign recip[g] = RV[SUM_W:0];
    end

    always_comb begin
        n_eff = ({1'b0, i_cfg.octaves} > 5'(MAX_OCTAVES)) ? NW'(MAX_OCTAVES)
                                                          : NW'(i_cfg.octaves);
        idx   = IDX_W'(n_eff - NW'(1));
        prod  = i_sum * recip[idx];
        dv    = (SUM_W'(1) << n_eff) - SUM_W'(1);
        qd    = SUM_W'(r_q0) * dv;
        rem   = r_s1 - qd;
        n_v   = r_q0 + VW'(rem >= dv);
        twice = {r_v, 1'b0};
        dev   = (twice >= (25'd1 << VW)) ? (twice - (25'd1 << VW)) : ((25'd1 << VW) - twice);
        fold  = (25'd1 << VW) - dev;
        if (n_eff == '0) begin
            n_noise = '0;
        end else if (i_cfg.ridged) begin
            n_noise = fold[VW:VW-16];
        end else begin
            n_noise = {1'b0, r_v[VW-1:VW-16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vo <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0    <= prod[SUM_W+VW-1:SUM_W];
            r_s1    <= i_sum;
            r_v     <= n_v;
            r_noise <= n_noise;
        end
    end

    assign o_valid = r_vo;
    assign o_noise = r_noise;

endmodule

@@ hw/rtl/fractal_value_noise_unit.sv @@
// ----------------------------------------------------------------------------
// fractal_value_noise_unit
// Fractal value noise over a 2D/3D lattice: one cell per octave, then
// normalization and ridge fold.
//
//   channel   dir   handshake        payload
//   i_point   in    valid/ready      x_coord, y_coord, z_coord (s32 Q16.16)
//   o_noise   out   valid/ready      noise_value (u17 Q1.16)
//   i_cfg_*   in    write enable     index 2b, data 32b
//
// One point per cycle while the output is not stalled; a point passes every
// octave cell in turn and then the registered normalizer.
// Reset clears valid flags and loads the configuration defaults.
// A result waiting in the output register with ready low holds the whole
// pipeline; i_point.ready follows.
// ----------------------------------------------------------------------------
module fractal_value_noise_unit #(
    parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF,
    parameter int HASH_BITS   = fvn_pkg::HASH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fvn_pkg::CFG_W-1:0]      i_cfg_data,
    fvn_point_if.sink                      i_point,
    fvn_noise_if.source                    o_noise
);

    localparam int SUM_W = fvn_pkg::VAL_W + MAX_OCTAVES;

    fvn_pkg::t_cfg     r_cfg;
    logic              en;
    logic              c_valid [MAX_OCTAVES+1];
    logic [31:0]       c_x     [MAX_OCTAVES+1];
    logic [31:0]       c_y     [MAX_OCTAVES+1];
    logic [31:0]       c_z     [MAX_OCTAVES+1];
    logic [SUM_W-1:0]  c_sum   [MAX_OCTAVES+1];
    logic              norm_valid;
    logic [16:0]       norm_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed    <= '0;
            r_cfg.octaves <= fvn_pkg::OCT_RESET;
            r_cfg.two_dim <= 1'b0;
            r_cfg.ridged  <= 1'b0;
        end else if (i_cfg_we) begin
            case (fvn_pkg::t_cfg_idx'(i_cfg_idx))
                fvn_pkg::CFG_SEED:    r_cfg.seed    <= i_cfg_data;
                fvn_pkg::CFG_OCTAVES: r_cfg.octaves <= i_cfg_data[3:0];
                fvn_pkg::CFG_TWO_DIM: r_cfg.two_dim <= i_cfg_data[0];
                fvn_pkg::CFG_RIDGED:  r_cfg.ridged  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en            = !norm_valid || o_noise.ready;
    assign i_point.ready = en;

    assign c_valid[0] = i_point.valid;
    assign c_x[0]     = i_point.x_coord;
    assign c_y[0]     = i_point.y_coord;
    assign c_z[0]     = i_point.z_coord;
    assign c_sum[0]   = '0;

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_cell
        fvn_cell #(
            .OCT         (o),
            .MAX_OCTAVES (MAX_OCTAVES),
            .FRAC_BITS   (FRAC_BITS),
            .HASH_BITS   (HASH_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cfg   (r_cfg),
            .i_valid (c_valid[o]),
            .i_x     (c_x[o]),
            .i_y     (c_y[o]),
            .i_z     (c_z[o]),
            .i_sum   (c_sum[o]),
            .o_valid (c_valid[o+1]),
            .o_x     (c_x[o+1]),
            .o_y     (c_y[o+1]),
            .o_z     (c_z[o+1]),
            .o_sum   (c_sum[o+1])
        );
    end

    fvn_norm #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (c_valid[MAX_OCTAVES]),
        .i_sum   (c_sum[MAX_OCTAVES]),
        .o_valid (norm_valid),
        .o_noise (norm_noise)
    );

    assign o_noise.valid       = norm_valid;
    assign o_noise.noise_value = norm_noise;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_noise.valid)
        else $error("output valid after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_noise.valid |-> o_noise.noise_value <= 17'h10000)
        else $error("noise value above one");

    a_stall_holds_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(c_valid[MAX_OCTAVES]) && $stable(c_sum[MAX_OCTAVES]))
        else $error("chain moved during stall");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fractal_value_noise_unit. Random and corner-case
// points are streamed through several register settings. An in-bench fBm
// model predicts every noise value, and each output transaction is compared
// in order.
// ----------------------------------------------------------------------------
class noise_scoreboard;
    bit [31:0]  seed;
    bit [3:0]   octaves;
    bit         two_dim;
    bit         ridged;
    bit [16:0]  expected_noise[$];
    int         errors;

    function new();
        seed    = 32'd0;
        octaves = fvn_pkg::OCT_RESET;
        two_dim = 1'b0;
        ridged  = 1'b0;
        errors  = 0;
    endfunction

    function bit [31:0] avalanche(bit [31:0] v);
        v = v ^ (v >> 16);
        v = v * 32'h7feb352d;
        v = v ^ (v >> 15);
        v = v * 32'h846ca68b;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function bit [63:0] lattice_hash(bit [31:0] s, bit [31:0] xi, bit [31:0] yi,
                                     bit [31:0] zi);
        bit [31:0] h;
        h = s;
        h ^= avalanche(xi * 32'h1f123bb5);
        h ^= avalanche(yi * 32'h9e3779b9);
        h ^= avalanche(zi * 32'h94d049bb);
        h = avalanche(h) & 32'h00ffffff;
        return {32'd0, h};
    endfunction

    function bit [63:0] smooth(bit [63:0] t);
        bit [63:0] p;
        p = t * t * (64'd196608 - 64'd2 * t);
        return p >> 32;
    endfunction

    function bit [63:0] lerp(bit [63:0] a, bit [63:0] b, bit [63:0] s);
        return (a * (64'd65536 - s) + b * s) >> 16;
    endfunction

    function bit [63:0] octave_noise(bit [63:0] c[3], int o, bit [31:0] s);
        bit [31:0] l0[3];
        bit [31:0] l1[3];
        bit [63:0] w[3];
        bit [63:0] u;
        bit [63:0] a00, a10, a01, a11;
        for (int k = 0; k < 3; k++) begin
            u = c[k] << o;
            l0[k] = u[47:16];
            l1[k] = l0[k] + 32'd1;
            w[k] = smooth({48'd0, u[15:0]});
        end
        if (two_dim) begin
            l0[1] = 32'd0;
            l1[1] = 32'd0;
            w[1] = 64'd0;
        end
        a00 = lerp(lattice_hash(s, l0[0], l0[1], l0[2]),
                   lattice_hash(s, l1[0], l0[1], l0[2]), w[0]);
        a10 = lerp(lattice_hash(s, l0[0], l1[1], l0[2]),
                   lattice_hash(s, l1[0], l1[1], l0[2]), w[0]);
        a01 = lerp(lattice_hash(s, l0[0], l0[1], l1[2]),
                   lattice_hash(s, l1[0], l0[1], l1[2]), w[0]);
        a11 = lerp(lattice_hash(s, l0[0], l1[1], l1[2]),
                   lattice_hash(s, l1[0], l1[1], l1[2]), w[0]);
        return lerp(lerp(a00, a10, w[1]), lerp(a01, a11, w[1]), w[2]);
    endfunction

    function bit [16:0] fbm_noise(bit [31:0] x, bit [31:0] y, bit [31:0] z);
        bit [63:0] c[3];
        bit [63:0] sum, v, d, res;
        bit [31:0] step;
        int n;
        c[0] = {{32{x[31]}}, x};
        c[1] = {{32{y[31]}}, y};
        c[2] = {{32{z[31]}}, z};
        n = (octaves > 8) ? 8 : octaves;
        if (n == 0) return 17'd0;
        step = two_dim ? fvn_pkg::STEP_2D : fvn_pkg::STEP_3D;
        sum = 64'd0;
        for (int o = 0; o < n; o++)
            sum = (sum << 1) + octave_noise(c, o, seed + o * step);
        v = sum / ((64'd1 << n) - 64'd1);
        if (ridged) begin
            d = (2 * v >= 64'h1000000) ? 2 * v - 64'h1000000 : 64'h1000000 - 2 * v;
            res = (64'h1000000 - d) >> 8;
        end else begin
            res = v >> 8;
        end
        return res[16:0];
    endfunction

    function void note_point(bit [31:0] x, bit [31:0] y, bit [31:0] z);
        expected_noise.insert(expected_noise.size(), fbm_noise(x, y, z));
    endfunction

    function void check_noise(bit [16:0] actual);
        bit [16:0] want;
        if (expected_noise.size() == 0) begin
            $display("%0t: unexpected noise transaction, expected none actual %h",
                     $time, actual);
            errors++;
            return;
        end
        want = expected_noise.pop_front();
        if (want !== actual) begin
            $display("%0t: noise_value mismatch, expected %h actual %h",
                     $time, want, actual);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    fvn_pkg::t_cfg_idx          cfg_idx = fvn_pkg::CFG_SEED;
    logic [fvn_pkg::CFG_W-1:0]  cfg_data = '0;
    logic                       quiet = 1'b0;
    int                         stall_left = 0;
    int                         cycles = 0;
    noise_scoreboard            sb = new();

    fvn_point_if point_ch();
    fvn_noise_if noise_ch();

    fractal_value_noise_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_point    (point_ch.sink),
        .o_noise    (noise_ch.source)
    );

    initial begin
        point_ch.valid   = 1'b0;
        point_ch.x_coord = '0;
        point_ch.y_coord = '0;
        point_ch.z_coord = '0;
        noise_ch.ready   = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (quiet) begin
            noise_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            noise_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: stall_left <= $urandom_range(1, 3);
                3:       stall_left <= $urandom_range(10, 40);
                default: stall_left <= 0;
            endcase
            noise_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && point_ch.valid && point_ch.ready)
            sb.note_point(point_ch.x_coord, point_ch.y_coord, point_ch.z_coord);
        if (i_rst_n && noise_ch.valid && noise_ch.ready)
            sb.check_noise(noise_ch.noise_value);
    end

    function automatic int idle_gap();
        if (quiet) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(1, 3);
            3:       return $urandom_range(10, 40);
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 4))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 32'h7ffff) - 32'h40000;
            3:       return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
            default: return {16'($urandom()), $urandom_range(0, 1) ? 16'hffff : 16'h0000};
        endcase
    endfunction

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.x_coord <= x;
        point_ch.y_coord <= y;
        point_ch.z_coord <= z;
        @(posedge i_clk);
        while (!(point_ch.valid && point_ch.ready)) @(posedge i_clk);
    endtask

    task automatic drain();
        point_ch.valid <= 1'b0;
        while (sb.expected_noise.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(fvn_pkg::t_cfg_idx idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            fvn_pkg::CFG_SEED:    sb.seed = data;
            fvn_pkg::CFG_OCTAVES: sb.octaves = data[3:0];
            fvn_pkg::CFG_TWO_DIM: sb.two_dim = data[0];
            fvn_pkg::CFG_RIDGED:  sb.ridged = data[0];
            default: ;
        endcase
    endtask

    initial begin
        logic [31:0] corners[8];
        int octave_plan[10];
        corners = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                    32'h0000ffff, 32'h00010000, 32'hffff0000, 32'h00008000};
        octave_plan = '{4, 0, 1, 8, 15, 2, 3, 5, 6, 7};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                write_reg(fvn_pkg::CFG_SEED, (p == 1) ? 32'hffffffff : $urandom());
                write_reg(fvn_pkg::CFG_OCTAVES, octave_plan[p]);
                write_reg(fvn_pkg::CFG_TWO_DIM, p % 2);
                write_reg(fvn_pkg::CFG_RIDGED, (p / 2) % 2);
            end
            quiet = (p % 3 == 2);
            if (p == 0 || p == 3) begin
                for (int i = 0; i < 8; i++)
                    send_point(corners[i], corners[7 - i], corners[(i + 3) % 8]);
                for (int i = 0; i < 8; i++)
                    send_point(corners[i], corners[i], corners[i]);
            end
            for (int i = 0; i < 150; i++)
                send_point(pick_coord(), pick_coord(), pick_coord());
            drain();
        end

        if (sb.errors == 0 && sb.expected_noise.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ fractal_value_noise_unit.f @@
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_point_if.sv
hw/rtl/fvn_noise_if.sv
hw/rtl/fvn_cell.sv
hw/rtl/fvn_norm.sv
hw/rtl/fractal_value_noise_unit.sv
tb/sv/testbench.sv
